// ----- design/three_voice_psg_sound_generator_assert.svh -----
// Assertion macros for the three-voice PSG sound generator.
// Used by the top level; expects aclk and aresetn in the including scope.
`ifndef THREE_VOICE_PSG_SOUND_GENERATOR_ASSERT_SVH
`define THREE_VOICE_PSG_SOUND_GENERATOR_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define PSG_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition that must hold whenever a trigger is true.
`define PSG_ASSERT_IMPLIES(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

`endif

// ----- design/tvpsg_pkg.sv -----
// Package for the three-voice PSG sound generator: command codes,
// register indexes and the volume table. No dependencies.
`default_nettype none

package tvpsg_pkg;

    // Command codes carried with each input item.
    typedef enum logic [1:0] {
        CMD_SELECT = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef logic [4:0]  reg_idx_t;
    typedef logic [10:0] level_t;

    localparam int NUM_REGS = 17;

    localparam reg_idx_t REG_TONE_A_COARSE = 5'd1;
    localparam reg_idx_t REG_TONE_B_COARSE = 5'd3;
    localparam reg_idx_t REG_TONE_C_COARSE = 5'd5;
    localparam reg_idx_t REG_NOISE         = 5'd6;
    localparam reg_idx_t REG_ENABLE        = 5'd7;
    localparam reg_idx_t REG_VOL_A         = 5'd8;
    localparam reg_idx_t REG_ENV_FINE      = 5'd11;
    localparam reg_idx_t REG_ENV_COARSE    = 5'd12;
    localparam reg_idx_t REG_SHAPE         = 5'd13;
    localparam reg_idx_t REG_PORT_B        = 5'd15;
    localparam reg_idx_t REG_FLOAT         = 5'd16;

    // Logarithmic volume table, full scale 1024.
    function automatic level_t vol_lookup(input logic [3:0] idx);
        level_t v;
        case (idx)
            4'd0:    v = 11'd0;
            4'd1:    v = 11'd14;
            4'd2:    v = 11'd20;
            4'd3:    v = 11'd29;
            4'd4:    v = 11'd43;
            4'd5:    v = 11'd63;
            4'd6:    v = 11'd86;
            4'd7:    v = 11'd140;
            4'd8:    v = 11'd173;
            4'd9:    v = 11'd271;
            4'd10:   v = 11'd361;
            4'd11:   v = 11'd460;
            4'd12:   v = 11'd584;
            4'd13:   v = 11'd703;
            4'd14:   v = 11'd868;
            default: v = 11'd1024;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/three_voice_psg_sound_generator.sv -----
// Top level of the three-voice PSG sound generator: register file, envelope,
// noise LFSR and tone counters. Depends on tvpsg_pkg and the assertion header.
`default_nettype none
// Usage:
// Input items arrive on the s_ stream: tdata[1:0] is the command (select,
// write, read, tick) and tdata[9:2] the data byte. Every item yields exactly
// one result on the m_ stream: read_data in tdata[7:0] and the three voice
// levels in tdata[18:8], [29:19] and [40:30]. A read returns the selected
// register and zero levels; a tick returns the levels and zero read_data;
// select and write return all zeros.
// From acceptance, an item passes through the input register, then a single
// pass of logic into the result register, where the state is updated as the
// item moves on, before the result is offered.
// Throughput is one item per cycle if no stall; both registers advance together.
// When the receiver stalls, the result register holds and the input register
// keeps one more item, after which s_tready falls.
// Synchronous active-low reset clears the register file, counters and valid
// flags, restores the power-on envelope shape and selects register 15.

`include "three_voice_psg_sound_generator_assert.svh"

module three_voice_psg_sound_generator
    import tvpsg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // command[1:0], data[9:2], zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // read_data[7:0], level_a[18:8],
                                        // level_b[29:19], level_c[40:30], zero fill
);

    // Input register.
    logic       in_valid_reg;
    cmd_t       in_cmd_reg;
    logic [7:0] in_data_reg;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] out_rd_reg;
    level_t     out_lvl_reg [3];

    // Generator state.
    logic [7:0]  reg_file_reg [NUM_REGS];
    logic [7:0]  reg_file_next [NUM_REGS];
    reg_idx_t    sel_reg, sel_next;
    logic [15:0] tone_cnt_reg [3];
    logic [15:0] tone_cnt_next [3];
    logic [7:0]  noise_cnt_reg, noise_cnt_next;
    logic [15:0] env_cnt_reg, env_cnt_next;
    logic [3:0]  env_step_reg, env_step_next;
    logic [3:0]  attack_reg, attack_next;
    logic        hold_reg, hold_next;
    logic        alt_reg, alt_next;
    logic        holding_reg, holding_next;
    logic [3:0]  square_reg, square_next;
    logic [16:0] lfsr_reg, lfsr_next;

    logic [7:0]  rd_next;
    level_t      lvl_next [3];

    logic advance;
    logic fire;

    // Handshake: both registers move whenever the result slot frees up.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= cmd_t'(s_tdata[1:0]);
            in_data_reg <= s_tdata[9:2];
        end
    end

    // Single pass: next state and result for the item in the input register.
    always_comb begin
        logic [7:0]  wv;
        logic [15:0] env_period;
        logic [16:0] env_inc;
        logic [7:0]  noise_period;
        logic [8:0]  noise_inc;
        logic [15:0] tone_period;
        logic [15:0] tone_cnt;
        logic [7:0]  vol;
        logic [3:0]  idx;
        logic        tone_on;
        logic        noise_on;

        for (int i = 0; i < NUM_REGS; i++) begin
            reg_file_next[i] = reg_file_reg[i];
        end
        for (int ch = 0; ch < 3; ch++) begin
            tone_cnt_next[ch] = tone_cnt_reg[ch];
            lvl_next[ch]      = '0;
        end
        sel_next       = sel_reg;
        noise_cnt_next = noise_cnt_reg;
        env_cnt_next   = env_cnt_reg;
        env_step_next  = env_step_reg;
        attack_next    = attack_reg;
        hold_next      = hold_reg;
        alt_next       = alt_reg;
        holding_next   = holding_reg;
        square_next    = square_reg;
        lfsr_next      = lfsr_reg;
        rd_next        = '0;
        wv             = in_data_reg;
        env_period     = '0;
        env_inc        = '0;
        noise_period   = '0;
        noise_inc      = '0;
        tone_period    = '0;
        tone_cnt       = '0;
        vol            = '0;
        idx            = '0;
        tone_on        = 1'b0;
        noise_on       = 1'b0;

        case (in_cmd_reg)
            CMD_SELECT: begin
                sel_next = (in_data_reg < 8'd16) ? in_data_reg[4:0] : REG_FLOAT;
            end
            CMD_WRITE: begin
                // Coarse tone and shape registers keep four bits.
                if (sel_reg == REG_TONE_A_COARSE || sel_reg == REG_TONE_B_COARSE ||
                    sel_reg == REG_TONE_C_COARSE || sel_reg == REG_SHAPE) begin
                    wv = {4'd0, in_data_reg[3:0]};
                end
                // A shape write restarts the envelope.
                if (sel_reg == REG_SHAPE) begin
                    holding_next  = 1'b0;
                    env_step_next = 4'd15;
                    attack_next   = wv[2] ? 4'd15 : 4'd0;
                    if (!wv[3]) begin
                        hold_next = 1'b1;
                        alt_next  = !wv[2];
                    end else begin
                        hold_next = wv[0];
                        alt_next  = wv[1];
                    end
                end
                reg_file_next[sel_reg] = wv;
            end
            CMD_READ: begin
                rd_next = reg_file_reg[sel_reg];
            end
            default: begin
                // Envelope counter and step.
                env_period = {reg_file_reg[REG_ENV_COARSE], reg_file_reg[REG_ENV_FINE]};
                env_inc    = {1'b0, env_cnt_reg} + 17'd1;
                if (!holding_reg) begin
                    if (env_inc >= {1'b0, env_period}) begin
                        env_inc = '0;
                        if (env_step_reg == 4'd0) begin
                            env_step_next = 4'd15;
                            if (alt_reg) begin
                                attack_next = attack_reg ^ 4'd15;
                            end
                            if (hold_reg) begin
                                holding_next = 1'b1;
                            end
                        end else begin
                            env_step_next = env_step_reg - 4'd1;
                        end
                    end
                    env_cnt_next = env_inc[15:0];
                end

                // Noise counter and LFSR run while any noise enable is on.
                noise_period = (reg_file_reg[REG_NOISE] == 8'd0) ? 8'd1
                                                                 : reg_file_reg[REG_NOISE];
                noise_inc    = {1'b0, noise_cnt_reg} + 9'd1;
                if (reg_file_reg[REG_ENABLE][5:3] != 3'b111) begin
                    if (noise_inc >= {1'b0, noise_period}) begin
                        noise_inc = '0;
                        if (lfsr_reg[0] ^ lfsr_reg[1]) begin
                            square_next[3] = !square_reg[3];
                        end
                        lfsr_next = {lfsr_reg[0] ^ lfsr_reg[3], lfsr_reg[16:1]};
                    end
                    noise_cnt_next = noise_inc[7:0];
                end

                // Tone counters and voice levels.
                for (int ch = 0; ch < 3; ch++) begin
                    tone_period = {reg_file_reg[5'(2 * ch + 1)], reg_file_reg[5'(2 * ch)]};
                    if (tone_period == 16'd0) begin
                        tone_period = 16'd1;
                    end
                    tone_cnt = tone_cnt_reg[ch] + 16'd2;
                    if (tone_cnt >= tone_period) begin
                        tone_cnt        = tone_cnt - tone_period;
                        square_next[ch] = !square_reg[ch];
                    end
                    tone_cnt_next[ch] = tone_cnt;
                    tone_on  = square_next[ch] | reg_file_reg[REG_ENABLE][ch];
                    noise_on = square_next[3] | reg_file_reg[REG_ENABLE][ch + 3];
                    vol = reg_file_reg[REG_VOL_A + 5'(ch)];
                    idx = vol[4] ? (env_step_next ^ attack_next) : vol[3:0];
                    if (tone_on && noise_on) begin
                        lvl_next[ch] = vol_lookup(idx);
                    end
                end

                // The floating register decays by one bit per tick.
                reg_file_next[REG_FLOAT] = {1'b0, reg_file_reg[REG_FLOAT][7:1]};
            end
        endcase
    end

    // State update as the item passes into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                reg_file_reg[i] <= '0;
            end
            for (int ch = 0; ch < 3; ch++) begin
                tone_cnt_reg[ch] <= '0;
            end
            sel_reg       <= REG_PORT_B;
            noise_cnt_reg <= '0;
            env_cnt_reg   <= '0;
            env_step_reg  <= 4'd15;
            attack_reg    <= 4'd0;
            hold_reg      <= 1'b1;
            alt_reg       <= 1'b1;
            holding_reg   <= 1'b0;
            square_reg    <= '0;
            lfsr_reg      <= 17'd1;
        end else if (fire) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                reg_file_reg[i] <= reg_file_next[i];
            end
            for (int ch = 0; ch < 3; ch++) begin
                tone_cnt_reg[ch] <= tone_cnt_next[ch];
            end
            sel_reg       <= sel_next;
            noise_cnt_reg <= noise_cnt_next;
            env_cnt_reg   <= env_cnt_next;
            env_step_reg  <= env_step_next;
            attack_reg    <= attack_next;
            hold_reg      <= hold_next;
            alt_reg       <= alt_next;
            holding_reg   <= holding_next;
            square_reg    <= square_next;
            lfsr_reg      <= lfsr_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_rd_reg <= rd_next;
            for (int ch = 0; ch < 3; ch++) begin
                out_lvl_reg[ch] <= lvl_next[ch];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_lvl_reg[2], out_lvl_reg[1], out_lvl_reg[0], out_rd_reg};

    // Checks on internal consistency.
    `PSG_ASSERT_ALWAYS(a_sel_range, sel_reg <= REG_FLOAT, "selected register out of range")
    `PSG_ASSERT_IMPLIES(a_hold_step, holding_reg, env_step_reg == 4'd15,
        "envelope holding with a step other than 15")
    `PSG_ASSERT_ALWAYS(a_coarse_mask,
        (reg_file_reg[REG_TONE_A_COARSE][7:4] == 4'd0) &&
        (reg_file_reg[REG_TONE_B_COARSE][7:4] == 4'd0) &&
        (reg_file_reg[REG_TONE_C_COARSE][7:4] == 4'd0) &&
        (reg_file_reg[REG_SHAPE][7:4] == 4'd0),
        "masked register holds upper bits")
    `PSG_ASSERT_IMPLIES(a_read_excl, out_valid_reg && (out_rd_reg != 8'd0),
        (out_lvl_reg[0] == '0) && (out_lvl_reg[1] == '0) && (out_lvl_reg[2] == '0),
        "read result carries voice levels")

endmodule

`default_nettype wire
